FILE: src/tfpg_pkg.sv
// tfpg_pkg: widths, codes and handshake structs of the timed force pulse generator
// no dependencies; imported by the interfaces and every module of the block

package tfpg_pkg;

   localparam int FORCE_W    = 16;
   localparam int MAX_W      = 15;
   localparam int TICK_W     = 16;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int AXES       = 3;
   localparam int Q_SHIFT    = 8;

   localparam int PROD_W     = 2 * FORCE_W;
   localparam int RAD_W      = PROD_W + 2 * Q_SHIFT;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SQRT_REM_W = ROOT_W + 2;
   localparam int NUM_W      = PROD_W + Q_SHIFT;
   localparam int DEN_W      = ROOT_W;
   localparam int SQRT_CNT_W = $clog2(ROOT_W);
   localparam int DIV_CNT_W  = $clog2(NUM_W);

   localparam logic [FORCE_W-1:0] MAG_MAX  = {1'b0, {(FORCE_W-1){1'b1}}};
   localparam logic [TICK_W-1:0]  AGE_MAX  = {TICK_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_ABORT = 2'd2,
      CMD_RAMP  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FORCE_X     = 3'd0,
      REG_FORCE_Y     = 3'd1,
      REG_FORCE_Z     = 3'd2,
      REG_MAX_FORCE   = 3'd3,
      REG_PULSE_TICKS = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

FILE: src/tfpg_if.sv
// tfpg_if: valid/ready channels of the pulse generator (command, result, register write)
// depends on tfpg_pkg for field widths

interface tfpg_req_if import tfpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [TICK_W-1:0] ramp_ticks;

   modport source (output valid, cmd, ramp_ticks, input ready);
   modport sink   (input valid, cmd, ramp_ticks, output ready);
endinterface

interface tfpg_rsp_if import tfpg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FORCE_W-1:0] out_x;
   logic signed [FORCE_W-1:0] out_y;
   logic signed [FORCE_W-1:0] out_z;
   logic                      pulse_on;
   logic                      just_ended;

   modport source (output valid, out_x, out_y, out_z, pulse_on, just_ended, input ready);
   modport sink   (input valid, out_x, out_y, out_z, pulse_on, just_ended, output ready);
endinterface

interface tfpg_csr_if import tfpg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/timed_force_pulse_generator_top.sv
// timed_force_pulse_generator_top: command sequencer, pulse state and register file
// depends on tfpg_pkg, tfpg_if, tfpg_isqrt and tfpg_div

// Each command transfer gives exactly one result transfer. Start, abort and ramp-down
// commands, and ticks that find the pulse idle or ending, go straight to the output
// state. A tick that outputs force makes four passes of the 16x16 multiplier for the
// squared magnitude and the squared limit, then, when the magnitude exceeds the limit,
// a 24-step square root and three 40-step divisions, and, while ramping, three more
// 40-step divisions; all divisions run on the one shared divider. Commands are not
// taken while a tick is in work; a finished result waits in the output register while
// the next command is taken. Register writes are always accepted.

module timed_force_pulse_generator_top import tfpg_pkg::*; (
   input logic         clock,
   input logic         reset,
   tfpg_req_if.sink    req_ch,
   tfpg_rsp_if.source  rsp_ch,
   tfpg_csr_if.sink    csr_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_CMP, S_ROOT_GO, S_ROOT_WAIT,
      S_LIM_MUL, S_LIM_GO, S_LIM_WAIT,
      S_RMP_CHK, S_RMP_MUL, S_RMP_GO, S_RMP_WAIT,
      S_FIN, S_OUT
   } state_type;

   // register file
   logic [FORCE_W-1:0] force_x_ff, force_y_ff, force_z_ff;
   logic [MAX_W-1:0]   max_ff;
   logic [TICK_W-1:0]  pulse_ticks_ff;

   // sequencer and pulse state
   state_type          state_ff, state_in;
   logic               active_ff, active_in;
   logic               ramping_ff, ramping_in;
   logic [TICK_W-1:0]  pulse_age_ff, pulse_age_in;
   logic [TICK_W-1:0]  ramp_age_ff, ramp_age_in;
   logic [TICK_W-1:0]  ramp_len_ff, ramp_len_in;
   logic               end_ff, end_in;
   logic [1:0]         k_ff, k_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [FORCE_W-1:0] mag_ff [AXES];
   logic [FORCE_W-1:0] mag_in [AXES];
   logic               neg_ff [AXES];
   logic               neg_in [AXES];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FORCE_W-1:0] rsp_x_ff, rsp_x_in;
   logic [FORCE_W-1:0] rsp_y_ff, rsp_y_in;
   logic [FORCE_W-1:0] rsp_z_ff, rsp_z_in;
   logic               rsp_on_ff, rsp_on_in;
   logic               rsp_end_ff, rsp_end_in;

   logic [FORCE_W-1:0] force_vec [AXES];
   logic [FORCE_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [TICK_W-1:0]  ramp_rem;
   logic               end_cond;
   cmd_type            cmd;
   sqrt_req_type       sqrt_req;
   sqrt_rsp_type       sqrt_rsp;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   tfpg_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   tfpg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_x_ff     <= '0;
         force_y_ff     <= '0;
         force_z_ff     <= '0;
         max_ff         <= '0;
         pulse_ticks_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_FORCE_X:     force_x_ff     <= csr_ch.data;
            REG_FORCE_Y:     force_y_ff     <= csr_ch.data;
            REG_FORCE_Z:     force_z_ff     <= csr_ch.data;
            REG_MAX_FORCE:   max_ff         <= csr_ch.data[MAX_W-1:0];
            REG_PULSE_TICKS: pulse_ticks_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign force_vec[0] = force_x_ff;
   assign force_vec[1] = force_y_ff;
   assign force_vec[2] = force_z_ff;

   assign cmd      = cmd_type'(req_ch.cmd);
   assign ramp_rem = ramp_len_ff - ramp_age_ff;
   assign end_cond = (pulse_age_ff >= pulse_ticks_ff) ||
                     (ramping_ff && (ramp_age_ff >= ramp_len_ff));
   assign mul_p    = {{FORCE_W{1'b0}}, mul_a} * {{FORCE_W{1'b0}}, mul_b};

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      ramping_in   = ramping_ff;
      pulse_age_in = pulse_age_ff;
      ramp_age_in  = ramp_age_ff;
      ramp_len_in  = ramp_len_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_end_in   = rsp_end_ff;
      mul_a        = '0;
      mul_b        = '0;
      sqrt_req     = '0;
      div_req      = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               end_in   = 1'b0;
               k_in     = '0;
               acc_in   = '0;
               state_in = S_OUT;
               for (int i = 0; i < AXES; i++) begin
                  mag_in[i] = '0;
                  neg_in[i] = 1'b0;
               end
               unique case (cmd)
                  CMD_START: begin
                     active_in    = 1'b1;
                     ramping_in   = 1'b0;
                     pulse_age_in = '0;
                  end
                  CMD_ABORT: begin
                     active_in  = 1'b0;
                     ramping_in = 1'b0;
                  end
                  CMD_RAMP: begin
                     if (active_ff && !ramping_ff) begin
                        ramping_in  = 1'b1;
                        ramp_age_in = '0;
                        ramp_len_in = req_ch.ramp_ticks;
                     end
                  end
                  CMD_TICK: begin
                     if (active_ff && end_cond) begin
                        active_in  = 1'b0;
                        ramping_in = 1'b0;
                        end_in     = 1'b1;
                     end else if (active_ff) begin
                        for (int i = 0; i < AXES; i++) begin
                           neg_in[i] = force_vec[i][FORCE_W-1];
                           mag_in[i] = force_vec[i][FORCE_W-1] ?
                                       (~force_vec[i] + 1'b1) : force_vec[i];
                        end
                        state_in = S_SQ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // squares of the three magnitudes, then the squared limit
         S_SQ: begin
            case (k_ff)
               2'd0: begin mul_a = mag_ff[0]; mul_b = mag_ff[0]; end
               2'd1: begin mul_a = mag_ff[1]; mul_b = mag_ff[1]; end
               2'd2: begin mul_a = mag_ff[2]; mul_b = mag_ff[2]; end
               default: begin mul_a = {1'b0, max_ff}; mul_b = {1'b0, max_ff}; end
            endcase
            prod_in = mul_p;
            if (k_ff != 2'd0) begin
               acc_in = acc_ff + prod_ff;
            end
            if (k_ff == 2'd3) begin
               state_in = S_CMP;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_CMP: begin
            k_in     = '0;
            state_in = (acc_ff > prod_ff) ? S_ROOT_GO : S_RMP_CHK;
         end
         S_ROOT_GO: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = {acc_ff, {(2 * Q_SHIFT){1'b0}}};
            state_in          = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (sqrt_rsp.done) begin
               state_in = S_LIM_MUL;
            end
         end
         S_LIM_MUL: begin
            mul_a    = mag_ff[k_ff];
            mul_b    = {1'b0, max_ff};
            prod_in  = mul_p;
            state_in = S_LIM_GO;
         end
         S_LIM_GO: begin
            div_req.start = 1'b1;
            div_req.numer = {prod_ff, {Q_SHIFT{1'b0}}} + NUM_W'(sqrt_rsp.root >> 1);
            div_req.denom = sqrt_rsp.root;
            state_in      = S_LIM_WAIT;
         end
         S_LIM_WAIT: begin
            if (div_rsp.done) begin
               mag_in[k_ff] = (div_rsp.quot > NUM_W'(max_ff)) ?
                              {1'b0, max_ff} : div_rsp.quot[FORCE_W-1:0];
               if (k_ff == 2'd2) begin
                  k_in     = '0;
                  state_in = S_RMP_CHK;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_LIM_MUL;
               end
            end
         end
         S_RMP_CHK: begin
            k_in     = '0;
            state_in = ramping_ff ? S_RMP_MUL : S_FIN;
         end
         S_RMP_MUL: begin
            mul_a    = mag_ff[k_ff];
            mul_b    = ramp_rem;
            prod_in  = mul_p;
            state_in = S_RMP_GO;
         end
         S_RMP_GO: begin
            div_req.start = 1'b1;
            div_req.numer = NUM_W'(prod_ff) + NUM_W'(ramp_len_ff >> 1);
            div_req.denom = DEN_W'(ramp_len_ff);
            state_in      = S_RMP_WAIT;
         end
         S_RMP_WAIT: begin
            if (div_rsp.done) begin
               mag_in[k_ff] = div_rsp.quot[FORCE_W-1:0];
               if (k_ff == 2'd2) begin
                  k_in     = '0;
                  state_in = S_FIN;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_RMP_MUL;
               end
            end
         end
         S_FIN: begin
            for (int i = 0; i < AXES; i++) begin
               if (mag_ff[i] > MAG_MAX) begin
                  mag_in[i] = MAG_MAX;
               end
            end
            if (pulse_age_ff != AGE_MAX) begin
               pulse_age_in = pulse_age_ff + 1'b1;
            end
            if (ramping_ff && (ramp_age_ff != AGE_MAX)) begin
               ramp_age_in = ramp_age_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = neg_ff[0] ? (~mag_ff[0] + 1'b1) : mag_ff[0];
               rsp_y_in     = neg_ff[1] ? (~mag_ff[1] + 1'b1) : mag_ff[1];
               rsp_z_in     = neg_ff[2] ? (~mag_ff[2] + 1'b1) : mag_ff[2];
               rsp_on_in    = active_ff;
               rsp_end_in   = end_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         ramping_ff   <= 1'b0;
         pulse_age_ff <= '0;
         ramp_age_ff  <= '0;
         ramp_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         ramping_ff   <= ramping_in;
         pulse_age_ff <= pulse_age_in;
         ramp_age_ff  <= ramp_age_in;
         ramp_len_ff  <= ramp_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff     <= end_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_on_ff  <= rsp_on_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_x      = rsp_x_ff;
   assign rsp_ch.out_y      = rsp_y_ff;
   assign rsp_ch.out_z      = rsp_z_ff;
   assign rsp_ch.pulse_on   = rsp_on_ff;
   assign rsp_ch.just_ended = rsp_end_ff;

`ifndef ASSERT_OFF
   a_ramp_needs_pulse: assert property (@(posedge clock) disable iff (reset)
      ramping_ff |-> active_ff)
      else $error("ramp flag set without an active pulse");

   a_end_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |->
         (!rsp_on_ff && rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_z_ff == '0))
      else $error("pulse end transfer carries force or an active flag");

   a_fin_only_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (active_ff && !end_ff))
      else $error("force computed for a pulse that is not running");

   a_root_over_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT_GO) |=> (state_ff == S_ROOT_WAIT && !sqrt_rsp.done))
      else $error("square root start not taken");
`endif

endmodule

FILE: src/tfpg_isqrt.sv
// tfpg_isqrt: bit-pair integer square root, one result bit per cycle
// depends on tfpg_pkg for widths and the sqrt request/response structs

module tfpg_isqrt import tfpg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);

   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [SQRT_REM_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_REM_W-1:0] rem_sh;
   logic [SQRT_REM_W-1:0] trial;

   assign rem_sh = {rem_ff[SQRT_REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (req.start) begin
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = SQRT_CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

FILE: src/tfpg_div.sv
// tfpg_div: restoring divider shared by the magnitude limit and the ramp scaling
// one quotient bit per cycle; depends on tfpg_pkg for widths and the divider structs

module tfpg_div import tfpg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       rem_sh;
   logic [DEN_W:0]       rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (req.start) begin
         quo_in  = req.numer;
         rem_in  = '0;
         den_in  = req.denom;
         cnt_in  = DIV_CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule
